FILE: rtl/dwrs_pkg.sv
// ----------------------------------------------------------------------------
// dwrs_pkg
// Shared widths, codes, reset values and lane interface types for the
// two-wheel ramp and stop profiler.
// ----------------------------------------------------------------------------
package dwrs_pkg;

  // Wheel ports on the top level; lane 0 drives the right wheel
  localparam int WHEELS        = 2;
  localparam int WHEEL_RIGHT   = 0;
  localparam int WHEEL_LEFT    = 1;
  localparam int DEFAULT_LANES = 2;

  // Q16.16 value width for velocities and distances
  localparam int VALUE_WIDTH = 32;

  localparam int OP_WIDTH        = 2;
  localparam int ACCEL_WIDTH     = 31;
  localparam int DPT_WIDTH       = 32;
  localparam int RATE_WIDTH      = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 32;

  localparam logic [OP_WIDTH-1:0] OP_TICK      = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_START     = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_START_VEL = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RIGHT_ACCEL   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEFT_ACCEL    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIST_PER_TICK = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SAMPLE_RATE   = 2'd3;

  localparam logic [ACCEL_WIDTH-1:0] ACCEL_RESET = 31'd65536;
  localparam logic [DPT_WIDTH-1:0]   DPT_RESET   = 32'd65536;
  localparam logic [RATE_WIDTH-1:0]  RATE_RESET  = 16'd1000;

  // Step strobes from the sequencer to every lane
  typedef struct packed {
    logic                load;
    logic                mul;
    logic                sat;
    logic                prod;
    logic                cmp;
    logic                commit;
    logic [OP_WIDTH-1:0] op;
    logic                stop_armed;
  } lane_ctrl_t;

  // State a lane takes on at commit
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] velocity;
    logic                          done;
    logic signed [VALUE_WIDTH-1:0] travelled;
  } lane_result_t;

endpackage

FILE: rtl/dwrs_lane.sv
// ----------------------------------------------------------------------------
// dwrs_lane
// One wheel: travelled distance, done test, stop-distance braking test by
// cross-multiplication and velocity slew, spread over the sequencer steps.
// ----------------------------------------------------------------------------
module dwrs_lane (
  input  logic                                        clk,
  input  logic                                        rst,
  input  dwrs_pkg::lane_ctrl_t                        ctrl,
  input  logic signed [dwrs_pkg::VALUE_WIDTH-1:0]     ticks,
  input  logic signed [dwrs_pkg::VALUE_WIDTH-1:0]     goal_distance,
  input  logic signed [dwrs_pkg::VALUE_WIDTH-1:0]     goal_velocity,
  input  logic        [dwrs_pkg::ACCEL_WIDTH-1:0]     accel,
  input  logic        [dwrs_pkg::DPT_WIDTH-1:0]       dist_per_tick,
  input  logic        [dwrs_pkg::RATE_WIDTH-1:0]      sample_rate,
  output dwrs_pkg::lane_result_t                      result
);

  localparam int VW   = dwrs_pkg::VALUE_WIDTH;
  localparam int AW   = dwrs_pkg::ACCEL_WIDTH;
  localparam int PW   = VW + dwrs_pkg::DPT_WIDTH + 1;
  localparam int ARW  = AW + dwrs_pkg::RATE_WIDTH;
  localparam int GW   = ARW + 1;
  localparam int HALF = GW / 2;
  localparam int PLW  = VW + HALF;
  localparam int PHW  = VW + GW - HALF;
  localparam int SDW  = VW + GW;
  localparam int RW   = VW + 2;

  // Architectural lane state
  logic signed [VW-1:0] velocity_now;
  logic signed [VW-1:0] velocity_goal;
  logic signed [VW-1:0] tick_baseline;
  logic signed [VW-1:0] distance_goal;
  logic signed [VW-1:0] distance_done;
  logic                 done_flag;

  logic signed [VW-1:0] velocity_now_next;
  logic signed [VW-1:0] velocity_goal_next;
  logic signed [VW-1:0] tick_baseline_next;
  logic signed [VW-1:0] distance_goal_next;
  logic signed [VW-1:0] distance_done_next;
  logic                 done_flag_next;

  // Per-transaction working registers
  logic signed [VW-1:0] tick_count;
  logic signed [VW-1:0] tick_diff;
  logic signed [VW-1:0] goal_distance_hold;
  logic signed [VW-1:0] goal_velocity_hold;
  logic        [VW-1:0] speed_mag;
  logic signed [PW-1:0] travel_prod;
  logic        [ARW-1:0] accel_rate;
  logic        [2*VW-1:0] speed_sq;
  logic signed [VW-1:0] travel;
  logic        [VW-1:0] remain_mag;
  logic                 remain_hit;
  logic        [PLW-1:0] part_lo;
  logic        [PHW-1:0] part_hi;
  logic                 brake;
  logic signed [VW-1:0] step_goal;
  logic signed [VW-1:0] step_zero;

  logic signed [PW-1:0] travel_full;
  logic        [PW-VW:0] travel_top;
  logic                 travel_ovf;
  logic signed [VW-1:0] travel_sat;
  logic                 goal_pos;
  logic signed [RW-1:0] remain;
  logic signed [RW-1:0] remain_dir;
  logic        [GW-1:0] stop_gain;
  logic        [SDW-1:0] stop_dist;
  logic                 stop_near;
  logic                 brake_en;
  logic signed [VW:0]   err_goal;
  logic signed [VW:0]   err_zero;

  function automatic logic signed [VW-1:0] slew_step(
    input logic signed [VW:0] err,
    input logic        [AW-1:0] acc
  );
    logic signed [VW:0] lim;
    logic signed [VW:0] neg_lim;
    lim     = $signed({{(VW + 1 - AW){1'b0}}, acc});
    neg_lim = -lim;
    if (err > lim) begin
      return lim[VW-1:0];
    end else if (err < neg_lim) begin
      return neg_lim[VW-1:0];
    end else begin
      return err[VW-1:0];
    end
  endfunction

  assign travel_full = tick_diff * $signed({1'b0, dist_per_tick});

  // Saturate the exact product to the signed value range
  assign travel_top = travel_prod[PW-1:VW-1];
  assign travel_ovf = !(&travel_top) && (|travel_top);
  assign travel_sat = travel_ovf ? {travel_prod[PW-1], {(VW-1){!travel_prod[PW-1]}}}
                                 : travel_prod[VW-1:0];

  assign goal_pos   = !distance_goal[VW-1] && (|distance_goal);
  assign remain     = {{2{distance_goal[VW-1]}}, distance_goal}
                    - {{2{travel_sat[VW-1]}}, travel_sat};
  assign remain_dir = goal_pos ? remain : -remain;

  assign stop_gain = {accel_rate, 1'b0};
  assign stop_dist = {part_hi, {HALF{1'b0}}} + {{(SDW - PLW){1'b0}}, part_lo};
  assign stop_near = (stop_dist <= {{(SDW - 2*VW){1'b0}}, speed_sq});
  assign brake_en  = ctrl.stop_armed && !done_flag && (ctrl.op == dwrs_pkg::OP_TICK)
                  && (|accel) && (|sample_rate);

  assign err_goal = {velocity_goal[VW-1], velocity_goal} - {velocity_now[VW-1], velocity_now};
  assign err_zero = -{velocity_now[VW-1], velocity_now};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tick_count         <= ticks;
      tick_diff          <= ticks - tick_baseline;
      goal_distance_hold <= goal_distance;
      goal_velocity_hold <= goal_velocity;
      speed_mag          <= velocity_now[VW-1] ? $unsigned(-velocity_now)
                                               : $unsigned(velocity_now);
    end
    if (ctrl.mul) begin
      travel_prod <= travel_full;
      accel_rate  <= accel * sample_rate;
      speed_sq    <= speed_mag * speed_mag;
    end
    if (ctrl.sat) begin
      travel     <= travel_sat;
      remain_hit <= remain_dir[RW-1] || (remain_dir == '0);
      remain_mag <= remain_dir[VW-1:0];
    end
    if (ctrl.prod) begin
      part_lo <= remain_mag * stop_gain[HALF-1:0];
      part_hi <= remain_mag * stop_gain[GW-1:HALF];
    end
    if (ctrl.cmp) begin
      brake     <= brake_en && (remain_hit || stop_near);
      step_goal <= slew_step(err_goal, accel);
      step_zero <= slew_step(err_zero, accel);
    end
  end

  always_comb begin
    velocity_now_next  = velocity_now;
    velocity_goal_next = velocity_goal;
    tick_baseline_next = tick_baseline;
    distance_goal_next = distance_goal;
    distance_done_next = distance_done;
    done_flag_next     = done_flag;
    case (ctrl.op) inside
      dwrs_pkg::OP_TICK: begin
        if (brake) begin
          velocity_goal_next = '0;
          velocity_now_next  = velocity_now + step_zero;
        end else begin
          velocity_now_next  = velocity_now + step_goal;
        end
        if (!done_flag) begin
          distance_done_next = travel;
          done_flag_next     = remain_hit;
        end
      end
      dwrs_pkg::OP_START, dwrs_pkg::OP_START_VEL: begin
        if (ctrl.op == dwrs_pkg::OP_START_VEL) begin
          velocity_goal_next = goal_velocity_hold;
        end
        tick_baseline_next = tick_count;
        distance_goal_next = goal_distance_hold;
        distance_done_next = '0;
        done_flag_next     = 1'b0;
      end
      default: begin
        // ignored operation: hold everything
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_now  <= '0;
      velocity_goal <= '0;
      tick_baseline <= '0;
      distance_goal <= '0;
      distance_done <= '0;
      done_flag     <= 1'b1;
    end else if (ctrl.commit) begin
      velocity_now  <= velocity_now_next;
      velocity_goal <= velocity_goal_next;
      tick_baseline <= tick_baseline_next;
      distance_goal <= distance_goal_next;
      distance_done <= distance_done_next;
      done_flag     <= done_flag_next;
    end
  end

  assign result.velocity  = velocity_now_next;
  assign result.done      = done_flag_next;
  assign result.travelled = distance_done_next;

endmodule

FILE: rtl/dwrs_seq.sv
// ----------------------------------------------------------------------------
// dwrs_seq
// Step sequencer shared by the lanes; also holds the stop-mode arm flag.
// ----------------------------------------------------------------------------
module dwrs_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [dwrs_pkg::OP_WIDTH-1:0]     operation,
  input  logic                              out_free,
  output logic                              in_stall,
  output dwrs_pkg::lane_ctrl_t              ctrl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_SAT    = 3'd2;
  localparam logic [2:0] S_PROD   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;

  logic [2:0]                      state;
  logic [2:0]                      state_next;
  logic [dwrs_pkg::OP_WIDTH-1:0]   op_hold;
  logic                            stop_armed;
  logic                            accept;
  logic                            commit;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state == S_COMMIT) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_MUL;
      S_MUL:    state_next = S_SAT;
      S_SAT:    state_next = S_PROD;
      S_PROD:   state_next = S_CMP;
      S_CMP:    state_next = S_COMMIT;
      S_COMMIT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stop_armed <= 1'b0;
    end else begin
      state <= state_next;
      if (commit && (op_hold == dwrs_pkg::OP_START || op_hold == dwrs_pkg::OP_START_VEL)) begin
        stop_armed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_hold <= operation;
    end
  end

  assign ctrl.load       = accept;
  assign ctrl.mul        = (state == S_MUL);
  assign ctrl.sat        = (state == S_SAT);
  assign ctrl.prod       = (state == S_PROD);
  assign ctrl.cmp        = (state == S_CMP);
  assign ctrl.commit     = commit;
  assign ctrl.op         = op_hold;
  assign ctrl.stop_armed = stop_armed;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MUL))
    else $error("accepted transaction did not start the multiply step");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stop_armed |=> stop_armed)
    else $error("stop mode disarmed without reset");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.load, ctrl.mul, ctrl.sat, ctrl.prod, ctrl.cmp, ctrl.commit}))
    else $error("more than one lane step strobed at once");

  a_commit_waits: assert property (@(posedge clk) disable iff (rst)
    ((state == S_COMMIT) && !out_free) |=> (state == S_COMMIT))
    else $error("result dropped while output register was full");
`endif

endmodule

FILE: rtl/dwrs_merge.sv
// ----------------------------------------------------------------------------
// dwrs_merge
// Output register: gathers the lane results into one result transaction and
// holds it until taken.
// ----------------------------------------------------------------------------
module dwrs_merge (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     commit,
  input  dwrs_pkg::lane_result_t                   results [dwrs_pkg::WHEELS],
  input  logic                                     out_stall,
  output logic                                     out_free,
  output logic                                     out_valid,
  output logic signed [dwrs_pkg::VALUE_WIDTH-1:0]  right_velocity,
  output logic signed [dwrs_pkg::VALUE_WIDTH-1:0]  left_velocity,
  output logic                                     right_done,
  output logic                                     left_done,
  output logic signed [dwrs_pkg::VALUE_WIDTH-1:0]  right_travelled,
  output logic signed [dwrs_pkg::VALUE_WIDTH-1:0]  left_travelled
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      right_velocity  <= results[dwrs_pkg::WHEEL_RIGHT].velocity;
      right_done      <= results[dwrs_pkg::WHEEL_RIGHT].done;
      right_travelled <= results[dwrs_pkg::WHEEL_RIGHT].travelled;
      left_velocity   <= results[dwrs_pkg::WHEEL_LEFT].velocity;
      left_done       <= results[dwrs_pkg::WHEEL_LEFT].done;
      left_travelled  <= results[dwrs_pkg::WHEEL_LEFT].travelled;
    end
  end

endmodule

FILE: rtl/dual_wheel_ramp_stop_profiler.sv
// ----------------------------------------------------------------------------
// dual_wheel_ramp_stop_profiler
// Two-wheel trapezoidal move profiler with stop-distance braking, one lane
// per wheel, Q16.16 throughout.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in      | input     | in_valid / in_stall  | operation, ticks, goals
//   out     | output    | out_valid / out_stall| velocity, done, travelled
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// Every transaction runs through load, two multiply steps (travel product,
// split stop-distance product) with saturation between them, compare, and
// then commit into the result register.
// A new transaction is accepted in the cycle after commit.
// A full, stalled output register holds the lanes at commit.
// Synchronous active-high reset; wheels reset to done, velocities zero.
// ----------------------------------------------------------------------------
module dual_wheel_ramp_stop_profiler #(
  parameter int LANES = dwrs_pkg::DEFAULT_LANES
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic [dwrs_pkg::OP_WIDTH-1:0]                operation,
  input  logic signed [dwrs_pkg::VALUE_WIDTH-1:0]      right_ticks,
  input  logic signed [dwrs_pkg::VALUE_WIDTH-1:0]      left_ticks,
  input  logic signed [dwrs_pkg::VALUE_WIDTH-1:0]      right_goal_distance,
  input  logic signed [dwrs_pkg::VALUE_WIDTH-1:0]      left_goal_distance,
  input  logic signed [dwrs_pkg::VALUE_WIDTH-1:0]      right_goal_velocity,
  input  logic signed [dwrs_pkg::VALUE_WIDTH-1:0]      left_goal_velocity,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic signed [dwrs_pkg::VALUE_WIDTH-1:0]      right_velocity,
  output logic signed [dwrs_pkg::VALUE_WIDTH-1:0]      left_velocity,
  output logic                                         right_done,
  output logic                                         left_done,
  output logic signed [dwrs_pkg::VALUE_WIDTH-1:0]      right_travelled,
  output logic signed [dwrs_pkg::VALUE_WIDTH-1:0]      left_travelled,
  input  logic                                         cfg_write,
  input  logic [dwrs_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
  input  logic [dwrs_pkg::CFG_DATA_WIDTH-1:0]          cfg_data
);

  localparam int WHEELS = dwrs_pkg::WHEELS;
  localparam int ACTIVE = (LANES < WHEELS) ? LANES : WHEELS;

  logic [dwrs_pkg::ACCEL_WIDTH-1:0]      accel [WHEELS];
  logic [dwrs_pkg::DPT_WIDTH-1:0]        dist_per_tick;
  logic [dwrs_pkg::RATE_WIDTH-1:0]       sample_rate;

  logic signed [dwrs_pkg::VALUE_WIDTH-1:0] lane_ticks    [WHEELS];
  logic signed [dwrs_pkg::VALUE_WIDTH-1:0] lane_goal_dist[WHEELS];
  logic signed [dwrs_pkg::VALUE_WIDTH-1:0] lane_goal_vel [WHEELS];
  dwrs_pkg::lane_result_t                  lane_result   [WHEELS];
  dwrs_pkg::lane_ctrl_t                    ctrl;
  logic                                    out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel[dwrs_pkg::WHEEL_RIGHT] <= dwrs_pkg::ACCEL_RESET;
      accel[dwrs_pkg::WHEEL_LEFT]  <= dwrs_pkg::ACCEL_RESET;
      dist_per_tick                <= dwrs_pkg::DPT_RESET;
      sample_rate                  <= dwrs_pkg::RATE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dwrs_pkg::CFG_RIGHT_ACCEL:
          accel[dwrs_pkg::WHEEL_RIGHT] <= cfg_data[dwrs_pkg::ACCEL_WIDTH-1:0];
        dwrs_pkg::CFG_LEFT_ACCEL:
          accel[dwrs_pkg::WHEEL_LEFT] <= cfg_data[dwrs_pkg::ACCEL_WIDTH-1:0];
        dwrs_pkg::CFG_DIST_PER_TICK:
          dist_per_tick <= cfg_data[dwrs_pkg::DPT_WIDTH-1:0];
        dwrs_pkg::CFG_SAMPLE_RATE:
          sample_rate <= cfg_data[dwrs_pkg::RATE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  assign lane_ticks[dwrs_pkg::WHEEL_RIGHT]     = right_ticks;
  assign lane_ticks[dwrs_pkg::WHEEL_LEFT]      = left_ticks;
  assign lane_goal_dist[dwrs_pkg::WHEEL_RIGHT] = right_goal_distance;
  assign lane_goal_dist[dwrs_pkg::WHEEL_LEFT]  = left_goal_distance;
  assign lane_goal_vel[dwrs_pkg::WHEEL_RIGHT]  = right_goal_velocity;
  assign lane_goal_vel[dwrs_pkg::WHEEL_LEFT]   = left_goal_velocity;

  dwrs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .out_free  (out_free),
    .in_stall  (in_stall),
    .ctrl      (ctrl)
  );

  for (genvar ln = 0; ln < WHEELS; ln++) begin : g_lane
    if (ln < ACTIVE) begin : g_on
      dwrs_lane u_lane (
        .clk           (clk),
        .rst           (rst),
        .ctrl          (ctrl),
        .ticks         (lane_ticks[ln]),
        .goal_distance (lane_goal_dist[ln]),
        .goal_velocity (lane_goal_vel[ln]),
        .accel         (accel[ln]),
        .dist_per_tick (dist_per_tick),
        .sample_rate   (sample_rate),
        .result        (lane_result[ln])
      );
    end else begin : g_off
      // no lane behind this wheel: report zeros
      assign lane_result[ln] = '0;
    end
  end

  dwrs_merge u_merge (
    .clk             (clk),
    .rst             (rst),
    .commit          (ctrl.commit),
    .results         (lane_result),
    .out_stall       (out_stall),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .right_velocity  (right_velocity),
    .left_velocity   (left_velocity),
    .right_done      (right_done),
    .left_done       (left_done),
    .right_travelled (right_travelled),
    .left_travelled  (left_travelled)
  );

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-wheel ramp and stop profiler. A short table
// of directed moves is followed by phases of random moves under different
// register settings and handshake pressure. Every result is checked against
// an in-bench model of the lanes or, for some directed rows, a fixed expected value.
// ----------------------------------------------------------------------------
module tb;
  import dwrs_pkg::*;

  localparam logic [OP_WIDTH-1:0] OP_IGNORED = 2'd3;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 216;
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 2000;

  localparam longint VAL_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint VAL_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [OP_WIDTH-1:0]                   op;
    logic [WHEELS-1:0][VALUE_WIDTH-1:0]    ticks;
    logic [WHEELS-1:0][VALUE_WIDTH-1:0]    goal_dist;
    logic [WHEELS-1:0][VALUE_WIDTH-1:0]    goal_vel;
  } move_item_t;

  typedef struct packed {
    logic [WHEELS-1:0][VALUE_WIDTH-1:0]    velocity;
    logic [WHEELS-1:0]                     done;
    logic [WHEELS-1:0][VALUE_WIDTH-1:0]    travelled;
  } wheel_report_t;

  typedef struct packed {
    move_item_t    item;
    logic          has_want;
    wheel_report_t want;
  } directed_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [OP_WIDTH-1:0]               operation = OP_TICK;
  logic signed [VALUE_WIDTH-1:0]     right_ticks = '0;
  logic signed [VALUE_WIDTH-1:0]     left_ticks = '0;
  logic signed [VALUE_WIDTH-1:0]     right_goal_distance = '0;
  logic signed [VALUE_WIDTH-1:0]     left_goal_distance = '0;
  logic signed [VALUE_WIDTH-1:0]     right_goal_velocity = '0;
  logic signed [VALUE_WIDTH-1:0]     left_goal_velocity = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [VALUE_WIDTH-1:0]     right_velocity;
  logic signed [VALUE_WIDTH-1:0]     left_velocity;
  logic                              right_done;
  logic                              left_done;
  logic signed [VALUE_WIDTH-1:0]     right_travelled;
  logic signed [VALUE_WIDTH-1:0]     left_travelled;
  logic                              cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0]        cfg_index = CFG_RIGHT_ACCEL;
  logic [CFG_DATA_WIDTH-1:0]         cfg_data = '0;

  // Lane model state and its copy of the registers
  logic signed [VALUE_WIDTH-1:0]     pr_vel       [WHEELS];
  logic signed [VALUE_WIDTH-1:0]     pr_vel_goal  [WHEELS];
  logic [VALUE_WIDTH-1:0]            pr_base      [WHEELS];
  logic signed [VALUE_WIDTH-1:0]     pr_goal_dist [WHEELS];
  logic signed [VALUE_WIDTH-1:0]     pr_trav      [WHEELS];
  logic                              pr_done      [WHEELS];
  logic                              pr_armed;
  logic [ACCEL_WIDTH-1:0]            pr_accel     [WHEELS];
  logic [DPT_WIDTH-1:0]              pr_dpt;
  logic [RATE_WIDTH-1:0]             pr_rate;

  wheel_report_t reports_due [$];
  wheel_report_t got_report;
  wheel_report_t due_report;
  int            mismatches = 0;
  int            sent_items = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;
  int            quiet_cycles = 0;
  int            cw;

  dual_wheel_ramp_stop_profiler dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .operation           (operation),
    .right_ticks         (right_ticks),
    .left_ticks          (left_ticks),
    .right_goal_distance (right_goal_distance),
    .left_goal_distance  (left_goal_distance),
    .right_goal_velocity (right_goal_velocity),
    .left_goal_velocity  (left_goal_velocity),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .right_velocity      (right_velocity),
    .left_velocity       (left_velocity),
    .right_done          (right_done),
    .left_done           (left_done),
    .right_travelled     (right_travelled),
    .left_travelled      (left_travelled),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the lane model by one transaction and return the result it shows
  function automatic wheel_report_t predict_wheel_report(input move_item_t it);
    wheel_report_t r;
    longint        diff;
    longint        trav;
    longint        rem;
    longint        s;
    longint        err;
    longint        lim;
    longint        nxt;
    logic [63:0]   k;
    logic [63:0]   mag;
    logic [63:0]   vsq;
    logic [127:0]  lhs;
    logic          brake;
    int            w;
    if (it.op == OP_TICK) begin
      for (w = 0; w < WHEELS; w++) begin
        if (!pr_done[w]) begin
          diff = longint'($signed(it.ticks[w] - pr_base[w]));
          trav = diff * longint'(pr_dpt);
          if (trav > VAL_MAX) trav = VAL_MAX;
          if (trav < VAL_MIN) trav = VAL_MIN;
          pr_trav[w] = trav[31:0];
          rem = longint'(pr_goal_dist[w]) - trav;
          s = (pr_goal_dist[w] > 0) ? rem : -rem;
          if (s <= 0) pr_done[w] = 1'b1;
          if (pr_armed && pr_accel[w] != 0 && pr_rate != 0) begin
            brake = (s <= 0);
            if (!brake) begin
              // compare stop distance by cross-multiplication, exactly
              k = 64'(pr_accel[w]) * 64'(pr_rate) * 64'd2;
              mag = (pr_vel[w] < 0) ? 64'(-longint'(pr_vel[w])) : 64'(longint'(pr_vel[w]));
              vsq = mag * mag;
              lhs = 128'(64'(s)) * 128'(k);
              brake = (lhs <= 128'(vsq));
            end
            if (brake) pr_vel_goal[w] = '0;
          end
        end
      end
      for (w = 0; w < WHEELS; w++) begin
        err = longint'(pr_vel_goal[w]) - longint'(pr_vel[w]);
        lim = longint'(pr_accel[w]);
        if (err > lim) err = lim;
        else if (err < -lim) err = -lim;
        nxt = longint'(pr_vel[w]) + err;
        pr_vel[w] = nxt[31:0];
      end
    end else if (it.op == OP_START || it.op == OP_START_VEL) begin
      for (w = 0; w < WHEELS; w++) begin
        if (it.op == OP_START_VEL) pr_vel_goal[w] = it.goal_vel[w];
        pr_base[w] = it.ticks[w];
        pr_goal_dist[w] = it.goal_dist[w];
        pr_trav[w] = '0;
        pr_done[w] = 1'b0;
      end
      pr_armed = 1'b1;
    end
    for (w = 0; w < WHEELS; w++) begin
      r.velocity[w] = pr_vel[w];
      r.done[w] = pr_done[w];
      r.travelled[w] = pr_trav[w];
    end
    return r;
  endfunction

  function automatic move_item_t mk_item(input logic [OP_WIDTH-1:0] op,
                                         input logic [31:0] rt, input logic [31:0] lt,
                                         input logic [31:0] rgd, input logic [31:0] lgd,
                                         input logic [31:0] rgv, input logic [31:0] lgv);
    move_item_t it;
    it.op = op;
    it.ticks[WHEEL_RIGHT] = rt;
    it.ticks[WHEEL_LEFT] = lt;
    it.goal_dist[WHEEL_RIGHT] = rgd;
    it.goal_dist[WHEEL_LEFT] = lgd;
    it.goal_vel[WHEEL_RIGHT] = rgv;
    it.goal_vel[WHEEL_LEFT] = lgv;
    return it;
  endfunction

  function automatic wheel_report_t mk_report(input logic [31:0] rv, input logic [31:0] lv,
                                              input logic rd, input logic ld,
                                              input logic [31:0] rtr, input logic [31:0] ltr);
    wheel_report_t r;
    r.velocity[WHEEL_RIGHT] = rv;
    r.velocity[WHEEL_LEFT] = lv;
    r.done[WHEEL_RIGHT] = rd;
    r.done[WHEEL_LEFT] = ld;
    r.travelled[WHEEL_RIGHT] = rtr;
    r.travelled[WHEEL_LEFT] = ltr;
    return r;
  endfunction

  function automatic move_item_t random_move();
    return mk_item(OP_WIDTH'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
  endfunction

  task automatic send_move(input move_item_t it, input logic has_want,
                           input wheel_report_t want);
    wheel_report_t due;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    operation <= it.op;
    right_ticks <= it.ticks[WHEEL_RIGHT];
    left_ticks <= it.ticks[WHEEL_LEFT];
    right_goal_distance <= it.goal_dist[WHEEL_RIGHT];
    left_goal_distance <= it.goal_dist[WHEEL_LEFT];
    right_goal_velocity <= it.goal_vel[WHEEL_RIGHT];
    left_goal_velocity <= it.goal_vel[WHEEL_LEFT];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    due = predict_wheel_report(it);
    reports_due.push_back(has_want ? want : due);
    sent_items++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_RIGHT_ACCEL:   pr_accel[WHEEL_RIGHT] = data[ACCEL_WIDTH-1:0];
      CFG_LEFT_ACCEL:    pr_accel[WHEEL_LEFT] = data[ACCEL_WIDTH-1:0];
      CFG_DIST_PER_TICK: pr_dpt = data[DPT_WIDTH-1:0];
      CFG_SAMPLE_RATE:   pr_rate = data[RATE_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // Hold the sender until every outstanding result is back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string field, input int w, input logic [31:0] e,
                             input logic [31:0] a);
    if (e !== a) begin
      if (mismatches < 10)
        $display("%s[%0d] mismatch: expected %h, got %h", field, w, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_report.velocity[WHEEL_RIGHT] = right_velocity;
        got_report.velocity[WHEEL_LEFT] = left_velocity;
        got_report.done[WHEEL_RIGHT] = right_done;
        got_report.done[WHEEL_LEFT] = left_done;
        got_report.travelled[WHEEL_RIGHT] = right_travelled;
        got_report.travelled[WHEEL_LEFT] = left_travelled;
        if (reports_due.size() == 0) begin
          if (mismatches < 10) $display("result transaction with nothing outstanding");
          mismatches++;
        end else begin
          due_report = reports_due.pop_front();
          for (cw = 0; cw < WHEELS; cw++) begin
            check_field("velocity", cw, due_report.velocity[cw], got_report.velocity[cw]);
            check_field("done", cw, 32'(due_report.done[cw]), 32'(got_report.done[cw]));
            check_field("travelled", cw, due_report.travelled[cw],
                        got_report.travelled[cw]);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    directed_row_t            rows [$];
    move_item_t               it;
    logic [VALUE_WIDTH-1:0]   pos  [WHEELS];
    logic                     neg  [WHEELS];
    int                       span [WHEELS];
    logic                     jumbled;
    logic [31:0]              step;
    longint                   g;
    logic [ACCEL_WIDTH-1:0]   ra;
    logic [ACCEL_WIDTH-1:0]   la;
    logic [DPT_WIDTH-1:0]     dpt_val;
    logic [RATE_WIDTH-1:0]    rate_val;
    int                       ph;
    int                       w;
    int                       j;
    int                       n_ticks;
    int                       span_max;
    int                       phase_end;

    for (w = 0; w < WHEELS; w++) begin
      pr_vel[w] = '0;
      pr_vel_goal[w] = '0;
      pr_base[w] = '0;
      pr_goal_dist[w] = '0;
      pr_trav[w] = '0;
      pr_done[w] = 1'b1;
      pr_accel[w] = ACCEL_RESET;
    end
    pr_armed = 1'b0;
    pr_dpt = DPT_RESET;
    pr_rate = RATE_RESET;

    // Idle lanes after reset, an ignored code, then a plain move to its goal
    rows.push_back('{item: mk_item(OP_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0),
                     has_want: 1'b1, want: mk_report(0, 0, 1'b1, 1'b1, 0, 0)});
    rows.push_back('{item: mk_item(OP_IGNORED, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF),
                     has_want: 1'b1, want: mk_report(0, 0, 1'b1, 1'b1, 0, 0)});
    rows.push_back('{item: mk_item(OP_START_VEL, 100, -5, 32'h000A_0000, 32'hFFF6_0000,
                                   32'h0002_0000, 32'hFFFE_0000),
                     has_want: 1'b1, want: mk_report(0, 0, 1'b0, 1'b0, 0, 0)});
    rows.push_back('{item: mk_item(OP_TICK, 101, -6, 0, 0, 0, 0), has_want: 1'b0, want: '0});
    rows.push_back('{item: mk_item(OP_TICK, 103, -8, 0, 0, 0, 0), has_want: 1'b0, want: '0});
    rows.push_back('{item: mk_item(OP_TICK, 110, -15, 0, 0, 0, 0), has_want: 1'b0, want: '0});
    rows.push_back('{item: mk_item(OP_TICK, 200, -100, 0, 0, 0, 0), has_want: 1'b0, want: '0});
    rows.push_back('{item: mk_item(OP_IGNORED, 0, 0, 0, 0, 0, 0), has_want: 1'b0, want: '0});
    // Zero goal distance finishes on the first tick
    rows.push_back('{item: mk_item(OP_START, 0, 0, 0, 0, 32'h0005_0000, 0),
                     has_want: 1'b0, want: '0});
    rows.push_back('{item: mk_item(OP_TICK, 0, 0, 0, 0, 0, 0), has_want: 1'b0, want: '0});
    // Extreme goals and saturating travel in both directions
    rows.push_back('{item: mk_item(OP_START_VEL, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000),
                     has_want: 1'b0, want: '0});
    rows.push_back('{item: mk_item(OP_TICK, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0),
                     has_want: 1'b0, want: '0});
    // Baselines across the wrap point, left lane moving away from its goal
    rows.push_back('{item: mk_item(OP_START_VEL, 32'h8000_0000, 32'h7FFF_FFFF,
                                   32'h0005_0000, 32'hFFFB_0000, 32'h7FFF_FFFF,
                                   32'h8000_0000),
                     has_want: 1'b0, want: '0});
    rows.push_back('{item: mk_item(OP_TICK, 32'h8000_0001, 32'h8000_0000, 0, 0, 0, 0),
                     has_want: 1'b0, want: '0});
    rows.push_back('{item: mk_item(OP_TICK, 32'h8000_0004, 32'h8000_0008, 0, 0, 0, 0),
                     has_want: 1'b0, want: '0});
    rows.push_back('{item: mk_item(OP_TICK, 32'h8000_0005, 32'h7FFF_FFF0, 0, 0, 0, 0),
                     has_want: 1'b0, want: '0});
    rows.push_back('{item: mk_item(OP_TICK, 32'h8000_0006, 32'h7FFF_FFF0, 0, 0, 0, 0),
                     has_want: 1'b0, want: '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[j]) send_move(rows[j].item, rows[j].has_want, rows[j].want);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          ra = ACCEL_WIDTH'($urandom_range(1, 32'h0001_0000));
          la = ACCEL_WIDTH'($urandom_range(1, 32'h0001_0000));
          dpt_val = DPT_RESET;
          rate_val = RATE_WIDTH'($urandom_range(1, 20));
        end
        1: begin
          ra = '0;
          la = '1;
          dpt_val = $urandom;
          rate_val = '1;
        end
        2: begin
          ra = '1;
          la = '0;
          dpt_val = '1;
          rate_val = RATE_WIDTH'(1);
        end
        3: begin
          ra = ACCEL_WIDTH'($urandom);
          la = ACCEL_WIDTH'($urandom);
          dpt_val = '0;
          rate_val = '0;
        end
        4: begin
          ra = ACCEL_WIDTH'($urandom);
          la = ACCEL_WIDTH'($urandom);
          dpt_val = $urandom;
          rate_val = RATE_WIDTH'($urandom);
        end
        default: begin
          ra = ACCEL_WIDTH'($urandom_range(16, 32'h0004_0000));
          la = ACCEL_WIDTH'($urandom_range(16, 32'h0004_0000));
          dpt_val = $urandom_range(32'h0000_1000, 32'h0004_0000);
          rate_val = RATE_WIDTH'($urandom_range(1, 200));
        end
      endcase
      write_reg(CFG_RIGHT_ACCEL, {1'($urandom_range(1)), ra});
      write_reg(CFG_LEFT_ACCEL, {1'($urandom_range(1)), la});
      write_reg(CFG_DIST_PER_TICK, dpt_val);
      write_reg(CFG_SAMPLE_RATE, {16'($urandom), rate_val});
      cfg_write <= 1'b0;

      idle_pct = (ph % 4 == 1) ? 55 : (ph % 4 == 3) ? 38 : 0;
      stall_pct = (ph % 4 == 2) ? 55 : (ph % 4 == 3) ? 38 : 0;

      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
        if ($urandom_range(99) < 15) begin
          send_move(random_move(), 1'b0, '0);
        end else begin
          // Start a move, then walk the encoders toward the goal
          it = random_move();
          it.op = $urandom_range(1) ? OP_START_VEL : OP_START;
          span_max = 1;
          for (w = 0; w < WHEELS; w++) begin
            neg[w] = 1'($urandom_range(1));
            span[w] = $urandom_range(1, 24);
            if (span[w] > span_max) span_max = span[w];
            pos[w] = it.ticks[w];
            g = longint'(span[w]) * longint'(pr_dpt) + longint'($urandom_range(0, 65535))
                - 64'sd32768;
            case ($urandom_range(9))
              0: g = 0;
              1: g = longint'($signed($urandom));
              default: if (neg[w]) g = -g;
            endcase
            if (g > VAL_MAX) g = VAL_MAX;
            if (g < VAL_MIN) g = VAL_MIN;
            it.goal_dist[w] = g[31:0];
            case ($urandom_range(3))
              0: it.goal_vel[w] = $urandom;
              3: it.goal_vel[w] = '0;
              default: it.goal_vel[w] = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            endcase
          end
          send_move(it, 1'b0, '0);
          jumbled = ($urandom_range(9) == 0);
          n_ticks = $urandom_range(span_max / 2 + 1, span_max * 2 + 2);
          for (j = 0; j < n_ticks; j++) begin
            it = random_move();
            it.op = OP_TICK;
            for (w = 0; w < WHEELS; w++) begin
              step = $urandom_range(0, 2);
              pos[w] = jumbled ? $urandom : (neg[w] ? pos[w] - step : pos[w] + step);
              it.ticks[w] = pos[w];
            end
            send_move(it, 1'b0, '0);
          end
        end
      end
      settle();
    end

    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: dual_wheel_ramp_stop_profiler.f
rtl/dwrs_pkg.sv
rtl/dwrs_lane.sv
rtl/dwrs_seq.sv
rtl/dwrs_merge.sv
rtl/dual_wheel_ramp_stop_profiler.sv
tb/sv/tb.sv
